### sv/sync_length_prefixed_deframer_core_macros.svh
// Assertion helpers used by the deframer RTL.
`ifndef SYNC_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define SLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### sv/slpd_pkg.sv
`timescale 1ns / 1ps

package slpd_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'h94;
    localparam logic [7:0]  SYNC_SECOND   = 8'hC3;
    localparam logic [15:0] MAX_LEN_RESET = 16'd512;

    // register index as seen at paddr[2]
    localparam logic        REG_MAX_PAYLOAD_LEN = 1'b0;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic        is_last;
        logic [15:0] frame_len;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
    } t_result;

endpackage

### sv/slpd_skid.sv
`timescale 1ns / 1ps

// Two-entry output stage: the input side stays ready while one result waits.
module slpd_skid
    import slpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no push can arrive while the skid entry is occupied
            if (i_pop_ready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_pop_ready) begin
            r_out_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_pop_ready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || i_pop_ready) begin
            r_out_data <= i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

### sv/sync_length_prefixed_deframer_core.sv
`timescale 1ns / 1ps
// A payload byte accepted from s_axis is registered in the output stage, via the skid entry when m_axis stalls.
// Throughput: one byte per cycle while s_axis_tready is high; header bytes yield no transfer.
// The two-entry output stage keeps s_axis_tready high while one result stalls.
// Reset (i_rst_n low, synchronous): hunt for the first sync byte, outputs
// empty, max_payload_len back to 512.
module sync_length_prefixed_deframer_core
    import slpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // payload bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [23:8] byte_index, [39:24] frame_len
    output logic        m_axis_tlast    // is_last
);

    logic [15:0] r_max_len;
    t_phase      r_phase, n_phase;
    logic [15:0] r_announced_len, n_announced_len;
    logic [15:0] r_payload_pos, n_payload_pos;

    logic        in_accept;
    logic        res_push;
    t_result     res_data;
    t_result     out_data;
    logic [16:0] next_pos;
    logic [15:0] full_len;

    // ---- configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_PAYLOAD_LEN) ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_MAX_PAYLOAD_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // ---- parser
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign next_pos  = {1'b0, r_payload_pos} + 17'd1;
    assign full_len  = {r_announced_len[15:8], s_axis_tdata};

    always_comb begin
        n_phase         = r_phase;
        n_announced_len = r_announced_len;
        n_payload_pos   = r_payload_pos;
        res_push        = 1'b0;
        res_data.data_byte  = s_axis_tdata;
        res_data.byte_index = r_payload_pos;
        res_data.frame_len  = r_announced_len;
        res_data.is_last    = (next_pos >= {1'b0, r_announced_len});
        if (in_accept) begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (s_axis_tdata == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    // a repeated first sync byte keeps waiting here
                    if (s_axis_tdata == SYNC_SECOND) begin
                        n_phase = PH_LEN_HI;
                    end else if (s_axis_tdata != SYNC_FIRST) begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN_HI: begin
                    n_announced_len = {s_axis_tdata, 8'd0};
                    n_phase         = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_announced_len = full_len;
                    n_payload_pos   = 16'd0;
                    if (full_len == 16'd0 || full_len > r_max_len) begin
                        n_phase = PH_SYNC1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res_push      = 1'b1;
                    n_payload_pos = next_pos[15:0];
                    if (res_data.is_last) begin
                        n_phase = PH_SYNC1;
                    end
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SYNC1;
            r_announced_len <= 16'd0;
            r_payload_pos   <= 16'd0;
        end else begin
            r_phase         <= n_phase;
            r_announced_len <= n_announced_len;
            r_payload_pos   <= n_payload_pos;
        end
    end

    // ---- output stage
    slpd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_data      (res_data),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (out_data),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_data.frame_len, out_data.byte_index, out_data.data_byte};
    assign m_axis_tlast = out_data.is_last;

    // ---- checks
    `include "sync_length_prefixed_deframer_core_macros.svh"

    `SLPD_ASSERT_NOW(a_last_marks_end, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tlast == (({1'b0, m_axis_tdata[23:8]} + 17'd1) == {1'b0, m_axis_tdata[39:24]})))
    `SLPD_ASSERT_NOW(a_payload_pos_in_range, i_clk, i_rst_n, r_phase == PH_PAYLOAD, (r_announced_len != 16'd0 && r_payload_pos < r_announced_len && r_announced_len <= 16'hFFFF))
    `SLPD_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)
    `SLPD_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, res_push && res_data.is_last, r_phase == PH_SYNC1)

endmodule

### tb/sync_length_prefixed_deframer_core_tb.sv
`timescale 1ns / 1ps

module sync_length_prefixed_deframer_core_tb;
    import slpd_pkg::*;

    localparam logic [2:0] ADDR_MAX_LEN = {REG_MAX_PAYLOAD_LEN, 2'b00};
    localparam logic [2:0] ADDR_UNUSED  = {~REG_MAX_PAYLOAD_LEN, 2'b00};
    localparam int         MAX_REPORTS  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [7:0] data_byte, [23:8] byte_index, [39:24] frame_len
    logic        m_axis_tlast;   // is_last

    sync_length_prefixed_deframer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // deframer state as predicted
    t_phase      parse_ph;
    logic [15:0] hdr_len;
    logic [15:0] payload_cnt;
    logic [15:0] max_len;

    t_result     pending_payload[$];

    int          mismatch_cnt;
    int          payload_seen;
    int          bytes_sent;
    int          cfg_writes;
    int          src_gap_pct;
    int          sink_stall_pct;
    int          hold_id;
    int          hold_len;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [16:0] nxt;
        bit          emit;
        emit = 1'b0;
        r    = '0;
        case (parse_ph)
            PH_SYNC1: begin
                if (b == SYNC_FIRST) parse_ph = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) parse_ph = PH_LEN_HI;
                else if (b != SYNC_FIRST) parse_ph = PH_SYNC1;
            end
            PH_LEN_HI: begin
                hdr_len  = {b, 8'h00};
                parse_ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_len     = {hdr_len[15:8], b};
                payload_cnt = '0;
                // limit is only looked at here
                if (hdr_len == 16'd0 || hdr_len > max_len) parse_ph = PH_SYNC1;
                else parse_ph = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                nxt          = {1'b0, payload_cnt} + 17'd1;
                r.data_byte  = b;
                r.byte_index = payload_cnt;
                r.frame_len  = hdr_len;
                r.is_last    = (nxt >= {1'b0, hdr_len});
                payload_cnt  = nxt[15:0];
                if (r.is_last) parse_ph = PH_SYNC1;
                emit = 1'b1;
            end
            default: begin
                parse_ph = PH_SYNC1;
            end
        endcase
        return emit;
    endfunction

    // sink side: random stalls plus long hold-offs on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_id != hold_seen) begin
                hold_seen = hold_id;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // payload checker
    initial begin
        t_result want;
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                payload_seen++;
                got.data_byte  = m_axis_tdata[7:0];
                got.byte_index = m_axis_tdata[23:8];
                got.frame_len  = m_axis_tdata[39:24];
                got.is_last    = m_axis_tlast;
                if (pending_payload.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected payload transfer: data %h idx %0d len %0d last %b",
                                 got.data_byte, got.byte_index, got.frame_len, got.is_last);
                end else begin
                    want = pending_payload.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"mismatch: exp data %h idx %0d len %0d last %b,",
                                      " got data %h idx %0d len %0d last %b"},
                                     want.data_byte, want.byte_index, want.frame_len,
                                     want.is_last, got.data_byte, got.byte_index,
                                     got.frame_len, got.is_last);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        t_result r;
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (deframe_byte(b, r)) pending_payload.push_back(r);
    endtask

    task automatic send_frame(input logic [15:0] len, input int unsigned n_payload);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (n_payload) send_byte(8'($urandom_range(255)));
    endtask

    // stop offering, wait for all payload, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_payload.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_MAX_PAYLOAD_LEN) max_len = value;
        cfg_writes++;
    endtask

    task automatic test_directed();
        byte unsigned seq[] = '{
            8'h94, 8'hC3, 8'h00, 8'h01, 8'h00,               // one-byte frame
            8'h94, 8'h94, 8'hC3, 8'h00, 8'h02, 8'hFF, 8'h94, // repeated first sync
            8'h94, 8'hC3, 8'h00, 8'h00,                      // zero length
            8'h94, 8'h5A,                                    // broken sync pair
            8'h94, 8'hC3, 8'h02, 8'h01                       // one over the reset limit
        };
        src_gap_pct     = 0;
        sink_stall_pct <= 0;
        foreach (seq[i]) send_byte(seq[i]);
        settle();
    endtask

    task automatic test_limits();
        write_reg(ADDR_MAX_LEN, 16'd0);
        send_frame(16'd1, 1);                  // zero limit drops everything
        write_reg(ADDR_UNUSED, 16'hFFFF);      // other index must be ignored
        send_frame(16'd1, 1);
        settle();
        write_reg(ADDR_MAX_LEN, 16'hFFFE);
        send_frame(16'hFFFF, 0);
        settle();
        write_reg(ADDR_MAX_LEN, 16'hFFFF);
        send_frame(16'h0102, 258);
        settle();
    endtask

    task automatic test_mid_frame_limit();
        write_reg(ADDR_MAX_LEN, 16'd20);
        send_frame(16'd10, 4);
        settle();
        // accepted frame must run to its end under a tighter limit
        write_reg(ADDR_MAX_LEN, 16'd2);
        repeat (6) send_byte(8'($urandom_range(255)));
        send_frame(16'd3, 0);
        send_byte(8'($urandom_range(255)));
        settle();
    endtask

    task automatic test_backpressure();
        write_reg(ADDR_MAX_LEN, MAX_LEN_RESET);
        src_gap_pct     = 0;
        sink_stall_pct <= 0;
        hold_len       <= 400;
        hold_id        <= hold_id + 1;
        send_frame(16'd40, 40);
        // sender waits for the whole frame before going on
        settle();
        send_frame(16'd3, 3);
        settle();
    endtask

    task automatic run_random_phase(input int gap, input int stall, input logic [15:0] limit,
                                    input int n_items);
        int unsigned kind;
        int unsigned len;
        int unsigned top;
        int          start;
        settle();
        write_reg(ADDR_MAX_LEN, limit);
        src_gap_pct     = gap;
        sink_stall_pct <= stall;
        start           = bytes_sent;
        while (bytes_sent - start < n_items) begin
            kind = $urandom_range(99);
            if (kind < 72) begin
                top = (limit > 16) ? 16 : limit;
                if (limit <= 64 && $urandom_range(19) == 0) len = limit;
                else len = $urandom_range(top, 1);
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(3, 1)) send_byte(SYNC_FIRST);
                send_frame(16'(len), len);
            end else if (kind < 80) begin
                send_frame(limit + 16'd1, 0);
            end else if (kind < 86) begin
                send_frame(16'd0, 0);
            end else if (kind < 92) begin
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(0, 0, MAX_LEN_RESET, 400);
        run_random_phase(53, 0, 16'd5, 400);
        run_random_phase(0, 53, 16'd64, 400);
        run_random_phase(14, 14, 16'd1, 400);
        settle();
    endtask

    initial begin
        parse_ph       = PH_SYNC1;
        hdr_len        = '0;
        payload_cnt    = '0;
        max_len        = MAX_LEN_RESET;
        mismatch_cnt   = 0;
        payload_seen   = 0;
        bytes_sent     = 0;
        cfg_writes     = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_id        = 0;
        hold_len       = 0;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        test_mid_frame_limit();
        test_backpressure();
        test_random();

        settle();
        repeat (6) @(posedge i_clk);
        if (pending_payload.size() != 0) mismatch_cnt++;

        $display("Covered %0d received bytes and %0d payload transfers with %0d register writes,",
                 bytes_sent, payload_seen, cfg_writes);
        $display("limits 0 to 65535, broken headers, mid-frame limit change and sink hold-off.");
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
